### rtl/lbpp_pkg.sv
package lbpp_pkg;

   // field widths
   localparam int IDX_W    = 12;
   localparam int RANGE_W  = 16;
   localparam int PIX_W    = 12;
   localparam int BEAR_W   = 19;
   localparam int START_W  = 19;
   localparam int STEP_W   = 13;
   localparam int DIM_W    = 13;
   localparam int STATUS_W = 2;

   // configuration port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;
   localparam int REG_W  = 3;

   localparam logic [REG_W-1:0] REG_ANGLE_START  = 3'd0;
   localparam logic [REG_W-1:0] REG_ANGLE_STEP   = 3'd1;
   localparam logic [REG_W-1:0] REG_RANGE_LOW    = 3'd2;
   localparam logic [REG_W-1:0] REG_RANGE_HIGH   = 3'd3;
   localparam logic [REG_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
   localparam logic [REG_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

   localparam logic signed [START_W-1:0] ANGLE_START_RST  = -19'sd205887;
   localparam logic [STEP_W-1:0]         ANGLE_STEP_RST   = 13'd1144;
   localparam logic [RANGE_W-1:0]        RANGE_LOW_RST    = 16'd150;
   localparam logic [RANGE_W-1:0]        RANGE_HIGH_RST   = 16'd12000;
   localparam logic [DIM_W-1:0]          IMAGE_WIDTH_RST  = 13'd640;
   localparam logic [DIM_W-1:0]          IMAGE_HEIGHT_RST = 13'd480;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_VIEW    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_GATED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BEHIND  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd3;

   // default parameters
   localparam int MAX_BEAMS_DEF  = 4096;
   localparam int TRIG_DEPTH_DEF = 1024;

   // angle constants, 2^-16 rad
   localparam int PI_Q     = 205887;
   localparam int TWO_PI_Q = 411775;
   localparam logic signed [BEAR_W-1:0] PI_BEAR = 19'sd205887;

   // angle wrap: offset angle and reciprocal of one turn
   localparam int AOFS_W = 26;
   localparam int QA_W   = 8;
   localparam int AM_W   = 19;
   localparam longint MA = (64'sd1 <<< AOFS_W) / TWO_PI_Q;

   // trig generation constants in Q30
   localparam longint unsigned PI30      = 64'd3373259426;
   localparam longint unsigned HALF_PI30 = 64'd1686629713;
   localparam longint unsigned ONE30     = 64'd1073741824;

   // intrinsics Q12
   localparam logic signed [22:0] FX_Q12 = 23'sd3850192;
   localparam logic signed [22:0] FY_Q12 = 23'sd3872853;
   localparam logic signed [22:0] CX_Q12 = 23'sd1383410;
   localparam logic signed [22:0] CY_Q12 = 23'sd905511;

   // rotation Q20
   localparam longint R00 = -42014;
   localparam longint R01 = 1047592;
   localparam longint R10 = 24777;
   localparam longint R11 = 18252;
   localparam longint R20 = -1047441;
   localparam longint R21 = -41589;

   // translation mm Q16
   localparam logic signed [23:0] TX_Q16 = -24'sd1109961;
   localparam logic signed [23:0] TY_Q16 = 24'sd2444263;
   localparam logic signed [23:0] TZ_Q16 = -24'sd4167936;

   // datapath widths
   localparam int PW    = 38;             // rotated trig table entry
   localparam int MW    = 55;             // range times table entry
   localparam int XW    = 36;             // camera frame coordinate
   localparam int NUM_W = 60;             // projected numerator
   localparam int DW    = NUM_W - PIX_W;  // divider remainder
   localparam int RND_SH = 20;

   typedef struct packed {
      logic                      gate;
      logic                      behind;
      logic [RANGE_W-1:0]        range;
      logic signed [BEAR_W-1:0]  bearing;
   } side_type;

   // sine of th (Q30, below two pi), result with 65536 = 1.0
   function automatic longint sine_q16(input longint unsigned th_in);
      longint unsigned th;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      logic            neg;
      th  = th_in;
      neg = 1'b0;
      if (th >= PI30) begin
         th  = th - PI30;
         neg = 1'b1;
      end
      if (th > HALF_PI30) th = PI30 - th;
      x2 = (th * th) >> 30;
      t  = ONE30 - ((x2 * ONE30) >> 30) / 110;
      t  = ONE30 - ((x2 * t) >> 30) / 72;
      t  = ONE30 - ((x2 * t) >> 30) / 42;
      t  = ONE30 - ((x2 * t) >> 30) / 20;
      t  = ONE30 - ((x2 * t) >> 30) / 6;
      s  = (th * t) >> 30;
      s  = (s + 64'd8192) >> 14;
      return neg ? -longint'(s) : longint'(s);
   endfunction

   // divide by 2^20 rounding half away from zero
   function automatic logic signed [XW-1:0] round_q20(input logic signed [MW-1:0] v);
      logic [MW-1:0] mag;
      logic [MW-1:0] q;
      mag = v[MW-1] ? MW'(-v) : MW'(v);
      q   = (mag + (MW'(1) << (RND_SH - 1))) >> RND_SH;
      return v[MW-1] ? -$signed(XW'(q)) : $signed(XW'(q));
   endfunction

endpackage

### rtl/lidar_beam_to_pixel_projection.sv
// the result is held in the output register behind the last divider stage
// throughput: one beam per cycle; a stalled result holds the whole pipeline
// depth is set by the angle wrap, the table index divide and the 12-stage
// bit-per-stage pixel divider
// reset: synchronous, clears all valid bits and loads register defaults
module lidar_beam_to_pixel_projection #(
   parameter int MAX_BEAMS        = lbpp_pkg::MAX_BEAMS_DEF,
   parameter int TRIG_TABLE_DEPTH = lbpp_pkg::TRIG_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lbpp_pkg::IDX_W-1:0]           req_beam_index,
   input  logic [lbpp_pkg::RANGE_W-1:0]         req_beam_range,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lbpp_pkg::STATUS_W-1:0]        rsp_status,
   output logic [lbpp_pkg::PIX_W-1:0]           rsp_pixel_x,
   output logic [lbpp_pkg::PIX_W-1:0]           rsp_pixel_y,
   output logic [lbpp_pkg::RANGE_W-1:0]         rsp_range_out,
   output logic signed [lbpp_pkg::BEAR_W-1:0]   rsp_bearing,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lbpp_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [lbpp_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [lbpp_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                 csr_pready
);
   import lbpp_pkg::*;

   localparam int MB_RECIP = (2 ** IDX_W) / MAX_BEAMS;
   localparam longint N_MAX = longint'(TWO_PI_Q - 1) * longint'(TRIG_TABLE_DEPTH)
                              + longint'(TWO_PI_Q / 2);
   localparam int NW  = $clog2(N_MAX + 1);
   localparam longint MK = (64'sd1 <<< NW) / TWO_PI_Q;
   localparam int MKW = $clog2(MK + 1);
   localparam int KW  = $clog2(TRIG_TABLE_DEPTH + 1);
   localparam int TW  = $clog2(TRIG_TABLE_DEPTH);

   // pipeline positions
   localparam int STG_BEARING = 5;
   localparam int STG_DEPTH   = 11;
   localparam int STG_DIV0    = 12;
   localparam int N_STG       = STG_DIV0 + PIX_W;

   typedef logic signed [PW-1:0] ptab_type [TRIG_TABLE_DEPTH];

   // rotated trig table: ra*cos + rb*sin for each table angle
   function automatic ptab_type build_ptab(input longint ra, input longint rb);
      ptab_type        tab;
      longint unsigned th;
      longint unsigned thc;
      longint          sn;
      longint          cs;
      for (int k = 0; k < TRIG_TABLE_DEPTH; k++) begin
         th  = (longint'(k) * 2 * PI30) / TRIG_TABLE_DEPTH;
         thc = th + HALF_PI30;
         if (thc >= 2 * PI30) thc = thc - 2 * PI30;
         sn  = sine_q16(th);
         cs  = sine_q16(thc);
         tab[k] = PW'(ra * cs + rb * sn);
      end
      return tab;
   endfunction

   localparam ptab_type PX_TAB = build_ptab(R00, R01);
   localparam ptab_type PY_TAB = build_ptab(R10, R11);
   localparam ptab_type PZ_TAB = build_ptab(R20, R21);

   // configuration registers
   logic signed [START_W-1:0] angle_start_ff;
   logic [STEP_W-1:0]         angle_step_ff;
   logic [RANGE_W-1:0]        range_low_ff;
   logic [RANGE_W-1:0]        range_high_ff;
   logic [DIM_W-1:0]          image_width_ff;
   logic [DIM_W-1:0]          image_height_ff;
   logic                      csr_wr;
   logic [REG_W-1:0]          csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_start_ff  <= ANGLE_START_RST;
         angle_step_ff   <= ANGLE_STEP_RST;
         range_low_ff    <= RANGE_LOW_RST;
         range_high_ff   <= RANGE_HIGH_RST;
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ANGLE_START:  angle_start_ff  <= csr_pwdata[START_W-1:0];
            REG_ANGLE_STEP:   angle_step_ff   <= csr_pwdata[STEP_W-1:0];
            REG_RANGE_LOW:    range_low_ff    <= csr_pwdata[RANGE_W-1:0];
            REG_RANGE_HIGH:   range_high_ff   <= csr_pwdata[RANGE_W-1:0];
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // register read
   always_comb begin
      case (csr_idx)
         REG_ANGLE_START:  csr_prdata = CSR_DW'(angle_start_ff);
         REG_ANGLE_STEP:   csr_prdata = CSR_DW'(angle_step_ff);
         REG_RANGE_LOW:    csr_prdata = CSR_DW'(range_low_ff);
         REG_RANGE_HIGH:   csr_prdata = CSR_DW'(range_high_ff);
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DW'(image_width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DW'(image_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // pipeline control: whole pipeline moves unless the result is stalled
   logic             pipe_en;
   logic [N_STG:1]   vld_ff;
   logic             rsp_valid_ff;
   side_type         side_ff [1:N_STG];

   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         vld_ff       <= {vld_ff[N_STG-1:1], req_valid};
         rsp_valid_ff <= vld_ff[N_STG];
      end
   end

   // stage 1: beam index modulo beam count, range gate
   logic [31:0]          s1_prod;
   logic [31:0]          s1_rem;
   logic [IDX_W-1:0]     idx1_ff;
   side_type             side1_in;

   always_comb begin
      s1_prod = 32'(req_beam_index) * 32'(MB_RECIP);
      s1_rem  = 32'(req_beam_index) - (s1_prod >> IDX_W) * 32'(MAX_BEAMS);
      if (s1_rem >= 32'(MAX_BEAMS)) s1_rem = s1_rem - 32'(MAX_BEAMS);
      side1_in.gate    = (req_beam_range < range_low_ff) || (req_beam_range > range_high_ff);
      side1_in.behind  = 1'b0;
      side1_in.range   = req_beam_range;
      side1_in.bearing = '0;
   end

   // stage 2: beam angle plus one turn, always positive
   logic [24:0]           s2_prod;
   logic signed [27:0]    s2_sum;
   logic [AOFS_W-1:0]     aofs2_ff;

   assign s2_prod = 25'(idx1_ff) * 25'(angle_step_ff);
   assign s2_sum  = 28'(angle_start_ff) + 28'(TWO_PI_Q) + 28'(s2_prod);

   // stage 3: turn count estimate
   logic [AOFS_W+QA_W-1:0] s3_prod;
   logic [AOFS_W-1:0]      aofs3_ff;
   logic [QA_W-1:0]        qa3_ff;

   assign s3_prod = (AOFS_W+QA_W)'(aofs2_ff) * (AOFS_W+QA_W)'(MA);

   // stage 4: angle reduced to one turn
   logic [26:0]        s4_rem;
   logic [AM_W-1:0]    am4_ff;

   always_comb begin
      s4_rem = 27'(aofs3_ff) - 27'(qa3_ff) * 27'(TWO_PI_Q);
      if (s4_rem >= 27'(TWO_PI_Q)) s4_rem = s4_rem - 27'(TWO_PI_Q);
   end

   // stage 5: bearing, scaled table numerator
   logic signed [BEAR_W:0] s5_bear;
   logic [NW-1:0]          n5_ff;

   assign s5_bear = (BEAR_W+1)'(PI_Q) - (BEAR_W+1)'(am4_ff);

   // stage 6: table index estimate
   logic [NW+MKW-1:0] s6_prod;
   logic [NW-1:0]     n6_ff;
   logic [KW-1:0]     kest6_ff;

   assign s6_prod = (NW+MKW)'(n5_ff) * (NW+MKW)'(MK);

   // stage 7: index correction and wrap
   logic [NW:0]   s7_rem;
   logic [KW:0]   s7_k;
   logic [TW-1:0] k7_ff;

   always_comb begin
      s7_rem = (NW+1)'(n6_ff) - (NW+1)'(kest6_ff) * (NW+1)'(TWO_PI_Q);
      s7_k   = (KW+1)'(kest6_ff);
      if (s7_rem >= (NW+1)'(TWO_PI_Q)) s7_k = s7_k + 1'b1;
      if (s7_k >= (KW+1)'(TRIG_TABLE_DEPTH)) s7_k = '0;
   end

   // stage 8: rotated trig table read
   logic signed [PW-1:0] ptx8_ff;
   logic signed [PW-1:0] pty8_ff;
   logic signed [PW-1:0] ptz8_ff;

   // stage 9: range times rotated trig
   logic signed [RANGE_W:0] s9_r;
   logic signed [MW-1:0]    mx9_ff;
   logic signed [MW-1:0]    my9_ff;
   logic signed [MW-1:0]    mz9_ff;

   assign s9_r = $signed({1'b0, side_ff[8].range});

   // stage 10: rounding and translation
   logic signed [XW-1:0] xc10_ff;
   logic signed [XW-1:0] yc10_ff;
   logic signed [XW-1:0] zc10_ff;

   // stage 11: projection numerators, depth check
   logic signed [NUM_W-1:0] nu11_ff;
   logic signed [NUM_W-1:0] nv11_ff;
   logic signed [XW-1:0]    zc11_ff;
   logic                    s11_behind;

   assign s11_behind = (zc10_ff <= 0);

   // stage 12 and divider stages
   logic [DW-1:0]    du_ff   [0:PIX_W];
   logic [DW-1:0]    dv_ff   [0:PIX_W];
   logic [DW-1:0]    dsor_ff [0:PIX_W];
   logic [PIX_W-1:0] qu_ff   [0:PIX_W];
   logic [PIX_W-1:0] qv_ff   [0:PIX_W];
   logic             negu_ff [0:PIX_W];
   logic             negv_ff [0:PIX_W];
   logic             ovfu_ff [1:PIX_W];
   logic             ovfv_ff [1:PIX_W];
   logic [NUM_W-1:0] s12_absu;
   logic [NUM_W-1:0] s12_absv;

   assign s12_absu = nu11_ff[NUM_W-1] ? NUM_W'(-nu11_ff) : NUM_W'(nu11_ff);
   assign s12_absv = nv11_ff[NUM_W-1] ? NUM_W'(-nv11_ff) : NUM_W'(nv11_ff);

   // front stages
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         idx1_ff  <= IDX_W'(s1_rem);
         aofs2_ff <= AOFS_W'(s2_sum);
         aofs3_ff <= aofs2_ff;
         qa3_ff   <= QA_W'(s3_prod >> AOFS_W);
         am4_ff   <= AM_W'(s4_rem);
         n5_ff    <= NW'(am4_ff) * NW'(TRIG_TABLE_DEPTH) + NW'(TWO_PI_Q / 2);
         n6_ff    <= n5_ff;
         kest6_ff <= KW'(s6_prod >> NW);
         k7_ff    <= TW'(s7_k);
         ptx8_ff  <= PX_TAB[k7_ff];
         pty8_ff  <= PY_TAB[k7_ff];
         ptz8_ff  <= PZ_TAB[k7_ff];
         mx9_ff   <= MW'(s9_r) * MW'(ptx8_ff);
         my9_ff   <= MW'(s9_r) * MW'(pty8_ff);
         mz9_ff   <= MW'(s9_r) * MW'(ptz8_ff);
         xc10_ff  <= round_q20(mx9_ff) + XW'(TX_Q16);
         yc10_ff  <= round_q20(my9_ff) + XW'(TY_Q16);
         zc10_ff  <= round_q20(mz9_ff) + XW'(TZ_Q16);
         nu11_ff  <= NUM_W'(FX_Q12) * NUM_W'(xc10_ff) + NUM_W'(CX_Q12) * NUM_W'(zc10_ff);
         nv11_ff  <= NUM_W'(FY_Q12) * NUM_W'(yc10_ff) + NUM_W'(CY_Q12) * NUM_W'(zc10_ff);
         zc11_ff  <= zc10_ff;
         du_ff[0]   <= DW'(s12_absu >> PIX_W);
         dv_ff[0]   <= DW'(s12_absv >> PIX_W);
         dsor_ff[0] <= DW'(zc11_ff);
         qu_ff[0]   <= '0;
         qv_ff[0]   <= '0;
         negu_ff[0] <= nu11_ff[NUM_W-1];
         negv_ff[0] <= nv11_ff[NUM_W-1];
      end
   end

   // side entries that pick up a result on the way
   side_type side5_in;
   side_type side11_in;

   always_comb begin
      side5_in          = side_ff[STG_BEARING-1];
      side5_in.bearing  = BEAR_W'(s5_bear);
      side11_in         = side_ff[STG_DEPTH-1];
      side11_in.behind  = s11_behind;
   end

   // side data travels with each item
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         side_ff[1] <= side1_in;
         for (int s = 2; s <= N_STG; s++) begin
            if (s == STG_BEARING) begin
               side_ff[s] <= side5_in;
            end else if (s == STG_DEPTH) begin
               side_ff[s] <= side11_in;
            end else begin
               side_ff[s] <= side_ff[s-1];
            end
         end
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar j = 1; j <= PIX_W; j++) begin : g_div
      localparam int B = PIX_W - j;
      logic [DW-1:0] sh;
      logic          geu;
      logic          gev;
      logic          ovu_in;
      logic          ovv_in;

      assign sh  = dsor_ff[j-1] << B;
      assign geu = du_ff[j-1] >= sh;
      assign gev = dv_ff[j-1] >= sh;

      if (j == 1) begin : g_first
         // negative numerator stays in view only below one divisor
         assign ovu_in = negu_ff[0] ? (du_ff[0] >= dsor_ff[0])
                                    : (du_ff[0] >= (dsor_ff[0] << PIX_W));
         assign ovv_in = negv_ff[0] ? (dv_ff[0] >= dsor_ff[0])
                                    : (dv_ff[0] >= (dsor_ff[0] << PIX_W));
      end else begin : g_rest
         assign ovu_in = ovfu_ff[j-1];
         assign ovv_in = ovfv_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            du_ff[j]   <= geu ? du_ff[j-1] - sh : du_ff[j-1];
            dv_ff[j]   <= gev ? dv_ff[j-1] - sh : dv_ff[j-1];
            qu_ff[j]   <= {qu_ff[j-1][PIX_W-2:0], geu};
            qv_ff[j]   <= {qv_ff[j-1][PIX_W-2:0], gev};
            dsor_ff[j] <= dsor_ff[j-1];
            negu_ff[j] <= negu_ff[j-1];
            negv_ff[j] <= negv_ff[j-1];
            ovfu_ff[j] <= ovu_in;
            ovfv_ff[j] <= ovv_in;
         end
      end
   end

   // final status and pixel select
   logic [STATUS_W-1:0] status_in;
   logic [PIX_W-1:0]    pix_x_in;
   logic [PIX_W-1:0]    pix_y_in;
   logic [PIX_W-1:0]    qx;
   logic [PIX_W-1:0]    qy;
   side_type            sd;

   assign sd = side_ff[N_STG];
   assign qx = negu_ff[PIX_W] ? '0 : qu_ff[PIX_W];
   assign qy = negv_ff[PIX_W] ? '0 : qv_ff[PIX_W];

   always_comb begin
      status_in = ST_VIEW;
      pix_x_in  = '0;
      pix_y_in  = '0;
      if (sd.gate) begin
         status_in = ST_GATED;
      end else if (sd.behind) begin
         status_in = ST_BEHIND;
      end else if (ovfu_ff[PIX_W] || ovfv_ff[PIX_W]
                   || ({1'b0, qx} >= image_width_ff)
                   || ({1'b0, qy} >= image_height_ff)) begin
         status_in = ST_OUTSIDE;
      end else begin
         pix_x_in = qx;
         pix_y_in = qy;
      end
   end

   // output register
   logic [STATUS_W-1:0]       status_ff;
   logic [PIX_W-1:0]          pix_x_ff;
   logic [PIX_W-1:0]          pix_y_ff;
   logic [RANGE_W-1:0]        range_ff;
   logic signed [BEAR_W-1:0]  bearing_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         status_ff  <= status_in;
         pix_x_ff   <= pix_x_in;
         pix_y_ff   <= pix_y_in;
         range_ff   <= sd.range;
         bearing_ff <= sd.bearing;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_pixel_x   = pix_x_ff;
   assign rsp_pixel_y   = pix_y_ff;
   assign rsp_range_out = range_ff;
   assign rsp_bearing   = bearing_ff;

   // stalled pipeline keeps its occupancy
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff))
      else $error("pipeline occupancy changed during stall");

   // pixels are zero unless the point is in view
   a_pix_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_VIEW)) |-> (rsp_pixel_x == '0 && rsp_pixel_y == '0))
      else $error("nonzero pixel on rejected point");

   // bearing stays within plus minus pi
   a_bear_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bearing >= -PI_BEAR && rsp_bearing <= PI_BEAR))
      else $error("bearing out of range");

endmodule
